FILE: rtl/qte_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qte_pkg
// Shared widths, constants and helper functions for the quaternion to
// Euler angle bin converter.
// ----------------------------------------------------------------------------
package qte_pkg;

    localparam int IN_WIDTH     = 16;
    localparam int NUM_BINS     = 18;
    localparam int BIN_W        = 5;

    localparam int Q14_W        = 16;
    localparam int PROD_W       = 32;
    localparam int COORD_W      = 37;
    localparam int T_W          = 30;
    localparam int RAD_W        = 57;
    localparam int ROOT_W       = 29;
    localparam int SQRT_STAGES  = 29;
    localparam int CORDIC_STEPS = 30;
    localparam int Z_W          = 34;
    localparam int ANG_W        = 33;
    localparam int CORDIC_LAT   = CORDIC_STEPS + 2;
    localparam int FRONT_LAT    = 3;
    localparam int PIPE_DEPTH   = FRONT_LAT + SQRT_STAGES + CORDIC_LAT;

    localparam logic signed [ANG_W-1:0] HALF_TURN    = ANG_W'(64'sd2147483648);
    localparam logic signed [ANG_W-1:0] QUARTER_TURN = ANG_W'(64'sd1073741824);

    localparam logic [30:0] ATAN_TBL [CORDIC_STEPS] = '{
        31'd536870912, 31'd316933406, 31'd167458907, 31'd85004756, 31'd42667331,
        31'd21354465, 31'd10679838, 31'd5340245, 31'd2670163, 31'd1335087,
        31'd667544, 31'd333772, 31'd166886, 31'd83443, 31'd41722,
        31'd20861, 31'd10430, 31'd5215, 31'd2608, 31'd1304,
        31'd652, 31'd326, 31'd163, 31'd81, 31'd41,
        31'd20, 31'd10, 31'd5, 31'd3, 31'd1
    };

    // Brings a raw input to Q1.14, flooring extra fraction bits.
    function automatic logic signed [Q14_W-1:0] to_q14(input logic signed [IN_WIDTH-1:0] v);
        logic signed [47:0] ext;
        logic signed [47:0] res;
        begin
            ext = 48'(v);
            if (IN_WIDTH >= Q14_W)
                res = ext >>> ((IN_WIDTH >= Q14_W) ? (IN_WIDTH - Q14_W) : 0);
            else
                res = ext <<< ((IN_WIDTH < Q14_W) ? (Q14_W - IN_WIDTH) : 0);
            return res[Q14_W-1:0];
        end
    endfunction

    // Bin over the full turn: ((a + 2^31) * NUM_BINS) >> 32.
    function automatic logic [BIN_W-1:0] full_bin(input logic signed [ANG_W-1:0] a);
        logic [ANG_W:0] s;
        logic [47:0]    p;
        begin
            s = (ANG_W+1)'(a) + (ANG_W+1)'(HALF_TURN);
            p = 48'(s[ANG_W-1:0]) * 48'(NUM_BINS);
            return p[32 +: BIN_W];
        end
    endfunction

    // Bin over the half turn: ((a + 2^30) * NUM_BINS) >> 31.
    function automatic logic [BIN_W-1:0] half_bin(input logic signed [ANG_W-1:0] a);
        logic [ANG_W:0] s;
        logic [47:0]    p;
        begin
            s = (ANG_W+1)'(a) + (ANG_W+1)'(QUARTER_TURN);
            p = 48'(s[ANG_W-1:0]) * 48'(NUM_BINS);
            return p[31 +: BIN_W];
        end
    endfunction

endpackage
`default_nettype wire

FILE: rtl/qte_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qte_front
// Three register stages: component products, the atan2 operands and the
// clamped asin argument, then the radicand for the pitch cosine.
// ----------------------------------------------------------------------------
module qte_front
(
    input  wire logic                                  clk,
    input  wire logic                                  en,
    input  wire logic signed [qte_pkg::IN_WIDTH-1:0]   quat_w,
    input  wire logic signed [qte_pkg::IN_WIDTH-1:0]   quat_x,
    input  wire logic signed [qte_pkg::IN_WIDTH-1:0]   quat_y,
    input  wire logic signed [qte_pkg::IN_WIDTH-1:0]   quat_z,
    output logic signed [qte_pkg::COORD_W-1:0]         roll_x,
    output logic signed [qte_pkg::COORD_W-1:0]         roll_y,
    output logic signed [qte_pkg::COORD_W-1:0]         yaw_x,
    output logic signed [qte_pkg::COORD_W-1:0]         yaw_y,
    output logic signed [qte_pkg::T_W-1:0]             t_out,
    output logic [qte_pkg::RAD_W-1:0]                  rad_out
);

    localparam int CW = qte_pkg::COORD_W;
    localparam int PW = qte_pkg::PROD_W;
    localparam logic signed [CW-1:0] ONE_Q28 = CW'(64'sd268435456);

    logic signed [qte_pkg::Q14_W-1:0] w, x, y, z;
    logic signed [PW-1:0] wx_reg, yz_reg, xx_reg, yy_reg, zz_reg, wz_reg, xy_reg;
    logic signed [PW-1:0] wy_reg, zx_reg;

    logic signed [CW-1:0] rx_reg, ry_reg, yx_reg, yy2_reg;
    logic signed [CW-1:0] rx_next, ry_next, yx_next, yy2_next, t_full;
    logic signed [qte_pkg::T_W-1:0] t_reg, t_next;

    logic signed [CW-1:0] rx2_reg, ry2_reg, yx2_reg, yyo_reg;
    logic signed [qte_pkg::T_W-1:0] t2_reg;
    logic signed [59:0] tsq, rad_full;
    logic [qte_pkg::RAD_W-1:0] rad_reg;

    assign w = qte_pkg::to_q14(quat_w);
    assign x = qte_pkg::to_q14(quat_x);
    assign y = qte_pkg::to_q14(quat_y);
    assign z = qte_pkg::to_q14(quat_z);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            wx_reg <= w * x;
            yz_reg <= y * z;
            xx_reg <= x * x;
            yy_reg <= y * y;
            zz_reg <= z * z;
            wz_reg <= w * z;
            xy_reg <= x * y;
            wy_reg <= w * y;
            zx_reg <= z * x;
        end
    end

    always_comb
    begin
        rx_next  = ONE_Q28 - ((CW'(xx_reg) + CW'(yy_reg)) <<< 1);
        ry_next  = (CW'(wx_reg) + CW'(yz_reg)) <<< 1;
        yx_next  = ONE_Q28 - ((CW'(yy_reg) + CW'(zz_reg)) <<< 1);
        yy2_next = (CW'(wz_reg) + CW'(xy_reg)) <<< 1;
        t_full   = (CW'(wy_reg) - CW'(zx_reg)) <<< 1;
        // Non-unit quaternions can push the asin argument past one.
        if (t_full > ONE_Q28)
            t_next = qte_pkg::T_W'(ONE_Q28);
        else if (t_full < -ONE_Q28)
            t_next = qte_pkg::T_W'(-ONE_Q28);
        else
            t_next = t_full[qte_pkg::T_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rx_reg  <= rx_next;
            ry_reg  <= ry_next;
            yx_reg  <= yx_next;
            yy2_reg <= yy2_next;
            t_reg   <= t_next;
        end
    end

    assign tsq      = 60'(t_reg) * 60'(t_reg);
    assign rad_full = (60'sd1 <<< 56) - tsq;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rx2_reg <= rx_reg;
            ry2_reg <= ry_reg;
            yx2_reg <= yx_reg;
            yyo_reg <= yy2_reg;
            t2_reg  <= t_reg;
            rad_reg <= rad_full[qte_pkg::RAD_W-1:0];
        end
    end

    assign roll_x  = rx2_reg;
    assign roll_y  = ry2_reg;
    assign yaw_x   = yx2_reg;
    assign yaw_y   = yyo_reg;
    assign t_out   = t2_reg;
    assign rad_out = rad_reg;

endmodule
`default_nettype wire

FILE: rtl/qte_isqrt.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qte_isqrt
// Floor integer square root, one result bit per register stage. The asin
// argument rides along so that it leaves together with its root.
// ----------------------------------------------------------------------------
module qte_isqrt
(
    input  wire logic                                clk,
    input  wire logic                                en,
    input  wire logic [qte_pkg::RAD_W-1:0]           rad_in,
    input  wire logic signed [qte_pkg::T_W-1:0]      t_in,
    output logic [qte_pkg::ROOT_W-1:0]               root_out,
    output logic signed [qte_pkg::T_W-1:0]           t_out
);

    localparam int N  = qte_pkg::SQRT_STAGES;
    localparam int RW = qte_pkg::RAD_W + 1;

    logic [RW-1:0]                  v_reg [1:N];
    logic [RW-1:0]                  r_reg [1:N];
    logic signed [qte_pkg::T_W-1:0] t_reg [1:N];

    for (genvar i = 0; i < N; i++)
    begin : g_step
        localparam logic [RW-1:0] BIT = RW'(1) << (2 * (N - 1 - i));
        logic [RW-1:0]                  v_cur, r_cur;
        logic signed [qte_pkg::T_W-1:0] t_cur;
        logic [RW-1:0]                  trial;
        logic [RW-1:0]                  v_next, r_next;

        // The first stage works on the radicand as it arrives.
        if (i == 0)
        begin : g_first
            assign v_cur = RW'(rad_in);
            assign r_cur = '0;
            assign t_cur = t_in;
        end
        else
        begin : g_rest
            assign v_cur = v_reg[i];
            assign r_cur = r_reg[i];
            assign t_cur = t_reg[i];
        end

        always_comb
        begin
            trial = r_cur + BIT;
            if (v_cur >= trial)
            begin
                v_next = v_cur - trial;
                r_next = (r_cur >> 1) + BIT;
            end
            else
            begin
                v_next = v_cur;
                r_next = r_cur >> 1;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                v_reg[i+1] <= v_next;
                r_reg[i+1] <= r_next;
                t_reg[i+1] <= t_cur;
            end
        end
    end

    assign root_out = r_reg[N][qte_pkg::ROOT_W-1:0];
    assign t_out    = t_reg[N];

endmodule
`default_nettype wire

FILE: rtl/qte_cordic.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qte_cordic
// Pipelined vectoring CORDIC for atan2 in binary angle units (2^32 per
// turn): one setup stage, one stage per rotation, one output stage.
// ----------------------------------------------------------------------------
module qte_cordic
(
    input  wire logic                                 clk,
    input  wire logic                                 en,
    input  wire logic signed [qte_pkg::COORD_W-1:0]   x_in,
    input  wire logic signed [qte_pkg::COORD_W-1:0]   y_in,
    output logic signed [qte_pkg::ANG_W-1:0]          angle,
    output logic                                      exact
);

    localparam int CW = qte_pkg::COORD_W;
    localparam int ZW = qte_pkg::Z_W;
    localparam int AW = qte_pkg::ANG_W;
    localparam int N  = qte_pkg::CORDIC_STEPS;

    localparam logic signed [ZW-1:0] Z_MAX = ZW'(qte_pkg::HALF_TURN) - ZW'(1);
    localparam logic signed [ZW-1:0] Z_QTR = ZW'(qte_pkg::QUARTER_TURN);

    logic signed [CW-1:0] x_reg  [0:N];
    logic signed [CW-1:0] y_reg  [0:N];
    logic signed [ZW-1:0] z_reg  [0:N];
    logic                 ex_reg [0:N];
    logic signed [AW-1:0] ea_reg [0:N];

    logic signed [CW-1:0] x0_next, y0_next;
    logic signed [ZW-1:0] z0_next;
    logic                 ex0_next;
    logic signed [AW-1:0] ea0_next;

    logic signed [AW-1:0] angle_reg, angle_next;
    logic                 exact_reg;

    // Points on an axis get an exact angle; the left half plane is turned
    // by a quarter so that the rotations start with x positive.
    always_comb
    begin
        x0_next  = x_in;
        y0_next  = y_in;
        z0_next  = '0;
        ex0_next = 1'b0;
        ea0_next = '0;
        if (y_in == 0)
        begin
            ex0_next = 1'b1;
            ea0_next = (x_in < 0) ? qte_pkg::HALF_TURN : '0;
        end
        else if (x_in == 0)
        begin
            ex0_next = 1'b1;
            ea0_next = (y_in > 0) ? qte_pkg::QUARTER_TURN : -qte_pkg::QUARTER_TURN;
        end
        else if (x_in < 0)
        begin
            if (y_in > 0)
            begin
                x0_next = y_in;
                y0_next = -x_in;
                z0_next = Z_QTR;
            end
            else
            begin
                x0_next = -y_in;
                y0_next = x_in;
                z0_next = -Z_QTR;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]  <= x0_next;
            y_reg[0]  <= y0_next;
            z_reg[0]  <= z0_next;
            ex_reg[0] <= ex0_next;
            ea_reg[0] <= ea0_next;
        end
    end

    for (genvar i = 0; i < N; i++)
    begin : g_rot
        logic signed [CW-1:0] dx, dy;
        logic signed [ZW-1:0] da;

        assign dx = y_reg[i] >>> i;
        assign dy = x_reg[i] >>> i;
        assign da = ZW'(qte_pkg::ATAN_TBL[i]);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (y_reg[i] > 0)
                begin
                    x_reg[i+1] <= x_reg[i] + dx;
                    y_reg[i+1] <= y_reg[i] - dy;
                    z_reg[i+1] <= z_reg[i] + da;
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] - dx;
                    y_reg[i+1] <= y_reg[i] + dy;
                    z_reg[i+1] <= z_reg[i] - da;
                end
                ex_reg[i+1] <= ex_reg[i];
                ea_reg[i+1] <= ea_reg[i];
            end
        end
    end

    // Approximate results stay strictly inside the open half turn.
    always_comb
    begin
        if (ex_reg[N])
            angle_next = ea_reg[N];
        else if (z_reg[N] > Z_MAX)
            angle_next = AW'(Z_MAX);
        else if (z_reg[N] < -Z_MAX)
            angle_next = AW'(-Z_MAX);
        else
            angle_next = z_reg[N][AW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            angle_reg <= angle_next;
            exact_reg <= ex_reg[N];
        end
    end

    assign angle = angle_reg;
    assign exact = exact_reg;

endmodule
`default_nettype wire

FILE: rtl/quaternion_to_euler_bins.sv
`default_nettype none
// ----------------------------------------------------------------------------
// quaternion_to_euler_bins
// Converts a unit quaternion into roll, pitch and yaw bin indices.
// ----------------------------------------------------------------------------
// One quaternion in signed Q1.14 is taken per clock cycle while in_stall is
// low and gives one item of three bin indices 0..18 (roll and yaw over minus
// pi to pi, pitch over minus half pi to half pi, truncating toward the lower
// bin). The pitch path is the longest: the products and sums of the front
// end, a 29-stage square root for the pitch cosine and a 32-stage CORDIC,
// plus the output register. Roll and yaw run their CORDICs beside the square
// root and wait in a delay line. in_stall rises only while an item sits in
// the output register and out_stall is high; the whole pipeline then holds.
// ----------------------------------------------------------------------------
module quaternion_to_euler_bins
(
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 in_valid,
    output logic                                      in_stall,
    input  wire logic signed [qte_pkg::IN_WIDTH-1:0]  quat_w,
    input  wire logic signed [qte_pkg::IN_WIDTH-1:0]  quat_x,
    input  wire logic signed [qte_pkg::IN_WIDTH-1:0]  quat_y,
    input  wire logic signed [qte_pkg::IN_WIDTH-1:0]  quat_z,
    output logic                                      out_valid,
    input  wire logic                                 out_stall,
    output logic [qte_pkg::BIN_W-1:0]                 roll_bin,
    output logic [qte_pkg::BIN_W-1:0]                 pitch_bin,
    output logic [qte_pkg::BIN_W-1:0]                 yaw_bin
);

    localparam int DEPTH = qte_pkg::PIPE_DEPTH;
    localparam int DLY   = qte_pkg::SQRT_STAGES;
    localparam int AW    = qte_pkg::ANG_W;
    localparam logic signed [AW-1:0] P_MAX = qte_pkg::QUARTER_TURN - AW'(1);

    logic en;

    logic signed [qte_pkg::COORD_W-1:0] roll_x, roll_y, yaw_x, yaw_y;
    logic signed [qte_pkg::T_W-1:0]     t_front, t_root;
    logic [qte_pkg::RAD_W-1:0]          rad;
    logic [qte_pkg::ROOT_W-1:0]         root;
    logic signed [qte_pkg::COORD_W-1:0] px, py;

    logic signed [AW-1:0] roll_ang, yaw_ang, pitch_ang, pitch_clamped;
    logic                 roll_ex, yaw_ex, pitch_ex;

    logic signed [AW-1:0] roll_dly_reg [0:DLY-1];
    logic signed [AW-1:0] yaw_dly_reg  [0:DLY-1];

    logic [DEPTH-1:0]   vld_reg, vld_next;
    logic               out_valid_reg;
    logic [qte_pkg::BIN_W-1:0] roll_reg, pitch_reg, yaw_reg;

    assign in_stall = out_valid_reg & out_stall;
    assign en       = ~in_stall;

    qte_front u_front
    (
        .clk     (clk),
        .en      (en),
        .quat_w  (quat_w),
        .quat_x  (quat_x),
        .quat_y  (quat_y),
        .quat_z  (quat_z),
        .roll_x  (roll_x),
        .roll_y  (roll_y),
        .yaw_x   (yaw_x),
        .yaw_y   (yaw_y),
        .t_out   (t_front),
        .rad_out (rad)
    );

    qte_isqrt u_isqrt
    (
        .clk      (clk),
        .en       (en),
        .rad_in   (rad),
        .t_in     (t_front),
        .root_out (root),
        .t_out    (t_root)
    );

    qte_cordic u_roll
    (
        .clk   (clk),
        .en    (en),
        .x_in  (roll_x),
        .y_in  (roll_y),
        .angle (roll_ang),
        .exact (roll_ex)
    );

    qte_cordic u_yaw
    (
        .clk   (clk),
        .en    (en),
        .x_in  (yaw_x),
        .y_in  (yaw_y),
        .angle (yaw_ang),
        .exact (yaw_ex)
    );

    assign px = qte_pkg::COORD_W'(root);
    assign py = qte_pkg::COORD_W'(t_root);

    qte_cordic u_pitch
    (
        .clk   (clk),
        .en    (en),
        .x_in  (px),
        .y_in  (py),
        .angle (pitch_ang),
        .exact (pitch_ex)
    );

    // Roll and yaw wait here for the square root ahead of the pitch CORDIC.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            roll_dly_reg[0] <= roll_ang;
            yaw_dly_reg[0]  <= yaw_ang;
            for (int k = 1; k < DLY; k++)
            begin
                roll_dly_reg[k] <= roll_dly_reg[k-1];
                yaw_dly_reg[k]  <= yaw_dly_reg[k-1];
            end
        end
    end

    // Only an asin argument of exactly plus or minus one reaches the bound.
    always_comb
    begin
        pitch_clamped = pitch_ang;
        if (!pitch_ex && pitch_ang > P_MAX)
            pitch_clamped = P_MAX;
        else if (!pitch_ex && pitch_ang < -P_MAX)
            pitch_clamped = -P_MAX;
    end

    assign vld_next = {vld_reg[DEPTH-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg       <= vld_next;
            out_valid_reg <= vld_reg[DEPTH-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            roll_reg  <= qte_pkg::full_bin(roll_dly_reg[DLY-1]);
            yaw_reg   <= qte_pkg::full_bin(yaw_dly_reg[DLY-1]);
            pitch_reg <= qte_pkg::half_bin(pitch_clamped);
        end
    end

    assign out_valid = out_valid_reg;
    assign roll_bin  = roll_reg;
    assign pitch_bin = pitch_reg;
    assign yaw_bin   = yaw_reg;

`ifndef SYNTHESIS
    a_roll_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> roll_bin <= qte_pkg::BIN_W'(qte_pkg::NUM_BINS))
        else $error("roll bin out of range");

    a_pitch_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pitch_bin <= qte_pkg::BIN_W'(qte_pkg::NUM_BINS))
        else $error("pitch bin out of range");

    a_yaw_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> yaw_bin <= qte_pkg::BIN_W'(qte_pkg::NUM_BINS))
        else $error("yaw bin out of range");

    a_hold_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |=> $stable(vld_reg) && out_valid)
        else $error("pipeline moved while the output was stalled");

    a_advance: assert property (@(posedge clk) disable iff (!rst_n)
        !in_stall |=> out_valid == $past(vld_reg[DEPTH-1]))
        else $error("output valid lost its item");
`endif

endmodule
`default_nettype wire

FILE: tb/sv/tb_quaternion_to_euler_bins.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb_quaternion_to_euler_bins
// Self-checking testbench for the quaternion to Euler angle bin converter.
// ----------------------------------------------------------------------------
// Quaternions are sent through the valid/stall input channel. Each accepted
// quaternion is converted by an integer model of the CORDIC datapath, and the
// expected bin triple is queued. Every output item is compared with the
// oldest queued triple. Directed corner quaternions come first, then random
// unit and non-unit quaternions under three idling profiles.
// ----------------------------------------------------------------------------
module tb_quaternion_to_euler_bins;

    localparam longint ONE_Q28  = 64'sd1 << 28;
    localparam longint HALF_T   = 64'sd1 << 31;
    localparam longint QUART_T  = 64'sd1 << 30;
    localparam int     LATENCY  = qte_pkg::PIPE_DEPTH + 1;

    typedef struct packed
    {
        logic [qte_pkg::BIN_W-1:0] roll;
        logic [qte_pkg::BIN_W-1:0] pitch;
        logic [qte_pkg::BIN_W-1:0] yaw;
    } bins_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic signed [qte_pkg::IN_WIDTH-1:0] quat_w;
    logic signed [qte_pkg::IN_WIDTH-1:0] quat_x;
    logic signed [qte_pkg::IN_WIDTH-1:0] quat_y;
    logic signed [qte_pkg::IN_WIDTH-1:0] quat_z;
    logic out_valid;
    logic out_stall;
    logic [qte_pkg::BIN_W-1:0] roll_bin;
    logic [qte_pkg::BIN_W-1:0] pitch_bin;
    logic [qte_pkg::BIN_W-1:0] yaw_bin;

    bins_t expected_bins[$];
    int    error_count;
    int    send_idle_pct;
    int    recv_idle_pct;

    quaternion_to_euler_bins dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .quat_w    (quat_w),
        .quat_x    (quat_x),
        .quat_y    (quat_y),
        .quat_z    (quat_z),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .roll_bin  (roll_bin),
        .pitch_bin (pitch_bin),
        .yaw_bin   (yaw_bin)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic longint floor_div2(longint v, int n);
        return v >>> n;
    endfunction

    function automatic longint int_sqrt(longint v);
        longint r;
        longint b;
        r = 0;
        b = 64'sd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
            begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // Vectoring CORDIC angle in binary units, 2^32 per turn.
    function automatic longint vector_angle(longint x, longint y);
        longint ang;
        longint t;
        longint dx;
        longint dy;
        ang = 0;
        if (y == 0)
            return (x < 0) ? HALF_T : 0;
        if (x == 0)
            return (y > 0) ? QUART_T : -QUART_T;
        if (x < 0)
        begin
            t = x;
            if (y > 0)
            begin
                x = y; y = -t; ang = QUART_T;
            end
            else
            begin
                x = -y; y = t; ang = -QUART_T;
            end
        end
        for (int i = 0; i < qte_pkg::CORDIC_STEPS; i++)
        begin
            dx = floor_div2(y, i);
            dy = floor_div2(x, i);
            if (y > 0)
            begin
                x = x + dx; y = y - dy; ang = ang + longint'(qte_pkg::ATAN_TBL[i]);
            end
            else
            begin
                x = x - dx; y = y + dy; ang = ang - longint'(qte_pkg::ATAN_TBL[i]);
            end
        end
        if (ang > HALF_T - 1)
            ang = HALF_T - 1;
        if (ang < -HALF_T + 1)
            ang = -HALF_T + 1;
        return ang;
    endfunction

    function automatic logic [qte_pkg::BIN_W-1:0] turn_bin(longint a, longint offs, int sh);
        longint p;
        p = ((a + offs) * qte_pkg::NUM_BINS) >>> sh;
        return p[qte_pkg::BIN_W-1:0];
    endfunction

    function automatic bins_t euler_bins(longint w, longint x, longint y, longint z);
        bins_t  b;
        longint pit;
        longint t;
        b.roll = turn_bin(vector_angle(ONE_Q28 - 2 * (x * x + y * y),
                                       2 * (w * x + y * z)), HALF_T, 32);
        b.yaw  = turn_bin(vector_angle(ONE_Q28 - 2 * (y * y + z * z),
                                       2 * (w * z + x * y)), HALF_T, 32);
        t = 2 * (w * y - z * x);
        if (t > ONE_Q28)
            t = ONE_Q28;
        if (t < -ONE_Q28)
            t = -ONE_Q28;
        pit = vector_angle(int_sqrt(ONE_Q28 * ONE_Q28 - t * t), t);
        if (t != ONE_Q28 && pit > QUART_T - 1)
            pit = QUART_T - 1;
        if (t != -ONE_Q28 && pit < -QUART_T + 1)
            pit = -QUART_T + 1;
        b.pitch = turn_bin(pit, QUART_T, 31);
        return b;
    endfunction

    // Valid stays high after an item is taken; a drain, or the next call when it
    // idles, lowers it, so back-to-back items see no gap.
    task automatic send_quat(input logic signed [15:0] w, input logic signed [15:0] x,
                             input logic signed [15:0] y, input logic signed [15:0] z);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        quat_w   <= w;
        quat_x   <= x;
        quat_y   <= y;
        quat_z   <= z;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        expected_bins.push_back(euler_bins(w, x, y, z));
    endtask

    // Send a roughly unit quaternion built from random components.
    task automatic send_unit_quat();
        real    a[4];
        real    n;
        for (int i = 0; i < 4; i++)
            a[i] = real'($urandom_range(2000)) - 1000.0;
        n = $sqrt(a[0] * a[0] + a[1] * a[1] + a[2] * a[2] + a[3] * a[3]);
        if (n < 1.0)
        begin
            a[0] = 1.0; n = 1.0;
        end
        send_quat(16'($rtoi(a[0] / n * 16384.0)), 16'($rtoi(a[1] / n * 16384.0)),
                  16'($rtoi(a[2] / n * 16384.0)), 16'($rtoi(a[3] / n * 16384.0)));
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_bins.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_directed();
        send_quat(16384, 0, 0, 0);
        send_quat(-16384, 0, 0, 0);
        send_quat(0, 16384, 0, 0);
        send_quat(0, 0, 16384, 0);
        send_quat(0, 0, 0, 16384);
        send_quat(0, -16384, 0, 0);
        send_quat(0, 0, -16384, 0);
        send_quat(0, 0, 0, -16384);
        send_quat(11585, 0, 11585, 0);
        send_quat(11585, 0, -11585, 0);
        send_quat(11585, 11585, 0, 0);
        send_quat(11585, 0, 0, -11585);
        send_quat(0, 0, 0, 0);
        send_quat(16384, 16384, 16384, 16384);
        send_quat(-16384, -16384, -16384, -16384);
        send_quat(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
        send_quat(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
        send_quat(16'sh7fff, 16'sh8000, 16'sh5555, 16'shaaaa);
        send_quat(8192, 8192, 8192, 8192);
        send_quat(8192, -8192, 8192, -8192);
    endtask

    task automatic test_random(input int count);
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(9) < 8)
                send_unit_quat();
            else
                send_quat(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
            if (i == count / 2)
            begin
                wait_drained();
                repeat (LATENCY) @(posedge clk);
            end
        end
    endtask

    always @(posedge clk)
    begin
        bins_t exp_b;
        if (rst_n)
        begin
            out_stall <= ($urandom_range(99) < recv_idle_pct);
            if (out_valid && !out_stall)
            begin
                if (expected_bins.size() == 0)
                begin
                    $display("%0t: unexpected item roll %0d pitch %0d yaw %0d",
                             $time, roll_bin, pitch_bin, yaw_bin);
                    error_count <= error_count + 1;
                end
                else
                begin
                    exp_b = expected_bins.pop_front();
                    if (exp_b.roll !== roll_bin || exp_b.pitch !== pitch_bin
                        || exp_b.yaw !== yaw_bin)
                    begin
                        $display("%0t: expected %0d/%0d/%0d actual %0d/%0d/%0d", $time,
                                 exp_b.roll, exp_b.pitch, exp_b.yaw,
                                 roll_bin, pitch_bin, yaw_bin);
                        error_count <= error_count + 1;
                    end
                end
            end
        end
    end

    initial
    begin
        #4000000;
        $display("quaternion_to_euler_bins: mismatch");
        $finish;
    end

    initial
    begin
        error_count   = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        out_stall     = 1'b0;
        quat_w        = '0;
        quat_x        = '0;
        quat_y        = '0;
        quat_z        = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        send_idle_pct = 17;
        recv_idle_pct = 84;
        test_random(400);
        send_idle_pct = 84;
        recv_idle_pct = 17;
        test_random(400);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(430);
        wait_drained();
        repeat (LATENCY + 5) @(posedge clk);
        if (error_count == 0 && expected_bins.size() == 0)
            $display("quaternion_to_euler_bins: match");
        else
            $display("quaternion_to_euler_bins: mismatch");
        $finish;
    end

endmodule
`default_nettype wire

FILE: files.f
rtl/qte_pkg.sv
rtl/qte_front.sv
rtl/qte_isqrt.sv
rtl/qte_cordic.sv
rtl/quaternion_to_euler_bins.sv
tb/sv/tb_quaternion_to_euler_bins.sv
